// ===== hdl/edcc_pkg.sv =====
// Shared types, codes and calendar tables for the epoch-day calendar converter.
// No dependencies; imported by the interfaces and all modules.
package edcc_pkg;

    localparam logic OP_TO_DAYS = 1'b0;
    localparam logic OP_TO_DATE = 1'b1;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    localparam logic [7:0] LAST_YEAR_OFF = 8'd199;
    localparam logic [3:0] MONTH_LAST    = 4'd11;
    localparam logic [3:0] MONTH_CLAMP   = 4'd12;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  year_since_1900;
        logic [3:0]  month_index;
        logic [4:0]  day_of_month;
        logic [15:0] day_count;
    } t_in_item;

    typedef struct packed {
        logic [15:0] result_days;
        logic [7:0]  result_year;
        logic [3:0]  result_month;
        logic [4:0]  result_mday;
        logic [2:0]  weekday;
        logic        status;
    } t_out_item;

    // request to the shared add/subtract unit
    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic        sub;
    } t_alu_req;

    typedef struct packed {
        logic [15:0] res;
        logic        ge;   // a >= b, valid when sub
    } t_alu_rsp;

    // year given as offset from 1900; covers 1900..2411
    function automatic logic is_leap(input logic [8:0] yoff);
        is_leap = (yoff[1:0] == 2'b00) && (yoff != 9'd0) && (yoff != 9'd200)
                  && (yoff != 9'd300) && (yoff != 9'd400);
    endfunction

    function automatic logic [15:0] year_len(input logic [8:0] yoff);
        year_len = is_leap(yoff) ? 16'd366 : 16'd365;
    endfunction

    // days before the first of month idx; idx of 12 and above gives the year length
    function automatic logic [15:0] cum_days(input logic leap, input logic [3:0] idx);
        logic [15:0] d;
        unique case (idx)
            4'd0:    d = 16'd0;
            4'd1:    d = 16'd31;
            4'd2:    d = 16'd59;
            4'd3:    d = 16'd90;
            4'd4:    d = 16'd120;
            4'd5:    d = 16'd151;
            4'd6:    d = 16'd181;
            4'd7:    d = 16'd212;
            4'd8:    d = 16'd243;
            4'd9:    d = 16'd273;
            4'd10:   d = 16'd304;
            4'd11:   d = 16'd334;
            default: d = 16'd365;
        endcase
        if (leap && (idx >= 4'd2)) begin
            d = d + 16'd1;
        end
        cum_days = d;
    endfunction

    // x mod 7: 8 = 1 (mod 7), so 3-bit groups are summed and folded
    function automatic logic [2:0] mod7(input logic [15:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = {3'd0, x[2:0]} + {3'd0, x[5:3]} + {3'd0, x[8:6]} + {3'd0, x[11:9]}
             + {3'd0, x[14:12]} + {5'd0, x[15]};
        s2 = {1'b0, s1[2:0]} + {1'b0, s1[5:3]};
        s3 = {1'b0, s2[2:0]} + {3'd0, s2[3]};
        mod7 = (s3 == 4'd7) ? 3'd0 : s3[2:0];
    endfunction

endpackage

// ===== hdl/edcc_in_if.sv =====
// Input and output item channels of the epoch-day calendar converter.
// Depends on edcc_pkg.
interface edcc_in_if import edcc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface edcc_out_if import edcc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/edcc_addsub.sv =====
// Shared 16-bit add/subtract unit with magnitude compare.
// Depends on edcc_pkg.
module edcc_addsub import edcc_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);
    logic [16:0] sum;

    always_comb begin
        if (i_req.sub) begin
            sum = {1'b0, i_req.a} + {1'b0, ~i_req.b} + 17'd1;
        end else begin
            sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
    end

    assign o_rsp.res = sum[15:0];
    assign o_rsp.ge  = sum[16];   // no borrow
endmodule

// ===== hdl/epoch_day_calendar_converter.sv =====
// Top level: sequencer around one shared add/subtract unit.
// Depends on edcc_pkg, edcc_in_if/edcc_out_if and edcc_addsub.
//
//  channel  dir  handshake           payload
//  i_in     in   valid/ready         opcode, year, month, day, day_count
//  o_out    out  valid/ready         days, year, month, mday, weekday, status
//
// The year walk through the shared adder sets the time from acceptance to a result.
// Date to days walks years from BASE_YEAR, adds the day of month and subtracts one;
// days to date walks years, then months. An out-of-range year goes straight to S_DONE.
// i_in.ready is high only while idle. A finished item waits in the output register;
// the next item may be taken meanwhile, and a full output register holds the block in
// its last state until o_out.ready. Synchronous active-low reset.
module epoch_day_calendar_converter import edcc_pkg::*; #(
    parameter int BASE_YEAR = 1970
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    edcc_in_if.sink           i_in,
    edcc_out_if.source        o_out
);
    localparam logic [8:0] BASE_OFF = 9'(BASE_YEAR - 1900);
    localparam int         PREV     = BASE_YEAR - 1;
    localparam int         BASE_WD  =
        (1 + 5 * (PREV % 4) + 4 * (PREV % 100) + 6 * (PREV % 400)) % 7;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_YEAR  = 3'd1;
    localparam logic [2:0] S_ADDD  = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_MONTH = 3'd4;
    localparam logic [2:0] S_MSUB  = 3'd5;
    localparam logic [2:0] S_MOD   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]  r_state, n_state;
    logic        r_op, n_op;
    logic        r_err, n_err;
    logic [8:0]  r_year, n_year;     // walking year, offset from 1900
    logic [8:0]  r_tgt, n_tgt;       // target year for date to days
    logic [3:0]  r_mon, n_mon;
    logic [4:0]  r_mday, n_mday;
    logic [15:0] r_days, n_days;     // accumulated or echoed day count
    logic [15:0] r_rem, n_rem;
    logic [2:0]  r_wd, n_wd;
    t_out_item   r_out, n_out;
    logic        r_out_valid, n_out_valid;

    t_alu_req    alu_req;
    t_alu_rsp    alu_rsp;
    logic        leap_cur;
    logic [3:0]  wd_sum;
    logic [2:0]  wd_final;

    edcc_addsub u_addsub (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign leap_cur = is_leap(r_year);

    assign wd_sum   = {1'b0, r_wd} + 4'(BASE_WD);
    assign wd_final = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        alu_req.a   = r_days;
        alu_req.b   = 16'd0;
        alu_req.sub = 1'b0;
        unique case (r_state)
            S_YEAR: begin
                if (r_op == OP_TO_DAYS) begin
                    alu_req.a = r_days;
                    alu_req.b = (r_year < r_tgt) ? year_len(r_year)
                                                 : cum_days(is_leap(r_tgt), r_mon);
                end else begin
                    alu_req.a   = r_rem;
                    alu_req.b   = year_len(r_year);
                    alu_req.sub = 1'b1;
                end
            end
            S_ADDD: begin
                alu_req.b = {11'd0, r_mday};
            end
            S_DEC: begin
                alu_req.b   = 16'd1;
                alu_req.sub = 1'b1;
            end
            S_MONTH: begin
                alu_req.a   = r_rem;
                alu_req.b   = cum_days(leap_cur, r_mon + 4'd1);
                alu_req.sub = 1'b1;
            end
            S_MSUB: begin
                alu_req.a   = r_rem;
                alu_req.b   = cum_days(leap_cur, r_mon);
                alu_req.sub = 1'b1;
            end
            default: begin
                alu_req.a = r_days;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_err       = r_err;
        n_year      = r_year;
        n_tgt       = r_tgt;
        n_mon       = r_mon;
        n_mday      = r_mday;
        n_days      = r_days;
        n_rem       = r_rem;
        n_wd        = r_wd;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op   = i_in.payload.opcode;
                    n_tgt  = {1'b0, i_in.payload.year_since_1900};
                    n_mon  = (i_in.payload.month_index > MONTH_CLAMP) ? MONTH_CLAMP
                                                                      : i_in.payload.month_index;
                    n_mday = i_in.payload.day_of_month;
                    n_year = BASE_OFF;
                    n_err  = 1'b0;
                    if (i_in.payload.opcode == OP_TO_DAYS) begin
                        n_days = 16'd0;
                        if (({1'b0, i_in.payload.year_since_1900} < BASE_OFF) ||
                            (i_in.payload.year_since_1900 > LAST_YEAR_OFF)) begin
                            n_err   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_YEAR;
                        end
                    end else begin
                        n_days  = i_in.payload.day_count;
                        n_rem   = i_in.payload.day_count;
                        n_state = S_YEAR;
                    end
                end
            end
            S_YEAR: begin
                if (r_op == OP_TO_DAYS) begin
                    n_days = alu_rsp.res;
                    if (r_year < r_tgt) begin
                        n_year = r_year + 9'd1;
                    end else begin
                        n_state = S_ADDD;
                    end
                end else begin
                    if (alu_rsp.ge) begin
                        n_rem  = alu_rsp.res;
                        n_year = r_year + 9'd1;
                    end else begin
                        n_mon   = 4'd0;
                        n_state = S_MONTH;
                    end
                end
            end
            S_ADDD: begin
                n_days  = alu_rsp.res;
                n_state = S_DEC;
            end
            S_DEC: begin
                n_days  = alu_rsp.res;
                n_state = S_MOD;
            end
            S_MONTH: begin
                if ((r_mon < MONTH_LAST) && alu_rsp.ge) begin
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_state = S_MSUB;
                end
            end
            S_MSUB: begin
                n_rem   = alu_rsp.res;
                n_state = S_MOD;
            end
            S_MOD: begin
                n_wd    = mod7(r_days);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_out       = '0;
                    if (r_err) begin
                        n_out.status = ST_RANGE;
                    end else begin
                        n_out.status      = ST_OK;
                        n_out.result_days = r_days;
                        n_out.weekday     = wd_final;
                        if (r_op == OP_TO_DATE) begin
                            n_out.result_year  = r_year[7:0];
                            n_out.result_month = r_mon;
                            n_out.result_mday  = r_rem[4:0] + 5'd1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_op   <= n_op;
        r_err  <= n_err;
        r_year <= n_year;
        r_tgt  <= n_tgt;
        r_mon  <= n_mon;
        r_mday <= n_mday;
        r_days <= n_days;
        r_rem  <= n_rem;
        r_wd   <= n_wd;
        r_out  <= n_out;
    end
endmodule
